/* hw/rtl/wfc_pkg.sv */
// Shared types, codes and helpers for the wall follow controller.
package wfc_pkg;

  // Input function codes
  localparam logic [1:0] FuncSample = 2'd0;
  localparam logic [1:0] FuncActivate = 2'd1;
  localparam logic [1:0] FuncDeactivate = 2'd2;

  // Motor command codes
  localparam logic [2:0] CmdStop = 3'd0;
  localparam logic [2:0] CmdFwd = 3'd1;
  localparam logic [2:0] CmdArcL = 3'd2;
  localparam logic [2:0] CmdArcR = 3'd3;
  localparam logic [2:0] CmdSpinL = 3'd4;
  localparam logic [2:0] CmdSpinR = 3'd5;

  // Phase codes
  localparam logic [2:0] PhSeek = 3'd0;
  localparam logic [2:0] PhSeekAlL = 3'd1;
  localparam logic [2:0] PhSeekAlR = 3'd2;
  localparam logic [2:0] PhFollow = 3'd3;
  localparam logic [2:0] PhMaxAppr = 3'd4;
  localparam logic [2:0] PhMaxExit = 3'd5;
  localparam logic [2:0] PhMinWait = 3'd6;
  localparam logic [2:0] PhFrontWait = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] CfgFollowSpeed = 3'd0;
  localparam logic [2:0] CfgTurnSpeed = 3'd1;
  localparam logic [2:0] CfgNearLimit = 3'd2;
  localparam logic [2:0] CfgMinLimit = 3'd3;
  localparam logic [2:0] CfgFarLimit = 3'd4;
  localparam logic [2:0] CfgClearLimit = 3'd5;
  localparam logic [2:0] CfgFrontCap = 3'd6;

  localparam logic [4:0] ApproachBoost = 5'd20;
  localparam logic [4:0] RetreatBoost = 5'd10;
  localparam logic [9:0] MaxSpeed = 10'd1023;

  // Most commands a single item can cause
  localparam int unsigned MaxResults = 2;
  localparam int unsigned CntW = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] left_dist;
    logic [7:0] center_dist;
    logic [7:0] right_dist;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [9:0] speed;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [9:0] speed;
  } result_t;

  typedef struct packed {
    logic [9:0] follow_speed;
    logic [9:0] turn_speed;
    logic [7:0] near_limit;
    logic [7:0] min_limit;
    logic [7:0] far_limit;
    logic [7:0] clear_limit;
    logic [7:0] front_cap;
  } cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       wall_found;
    logic       wall_side;
    logic       active;
    logic [7:0] exit_dist;
  } state_t;

  function automatic logic [9:0] sat_add(input logic [9:0] a, input logic [4:0] b);
    logic [10:0] sum;
    sum = {1'b0, a} + {6'd0, b};
    return sum[10] ? MaxSpeed : sum[9:0];
  endfunction

endpackage

/* hw/rtl/wfc_cfg_regs.sv */
// Configuration register file of the wall follow controller.
module wfc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [9:0]    cfg_data_i,
  output wfc_pkg::cfg_t cfg_o
);

  wfc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wfc_pkg::CfgFollowSpeed:   cfg_d.follow_speed = cfg_data_i;
        wfc_pkg::CfgTurnSpeed:     cfg_d.turn_speed = cfg_data_i;
        wfc_pkg::CfgNearLimit:     cfg_d.near_limit = cfg_data_i[7:0];
        wfc_pkg::CfgMinLimit:      cfg_d.min_limit = cfg_data_i[7:0];
        wfc_pkg::CfgFarLimit:      cfg_d.far_limit = cfg_data_i[7:0];
        wfc_pkg::CfgClearLimit:    cfg_d.clear_limit = cfg_data_i[7:0];
        wfc_pkg::CfgFrontCap:      cfg_d.front_cap = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.follow_speed <= 10'd100;
      cfg_q.turn_speed <= 10'd10;
      cfg_q.near_limit <= 8'd7;
      cfg_q.min_limit <= 8'd4;
      cfg_q.far_limit <= 8'd40;
      cfg_q.clear_limit <= 8'd200;
      cfg_q.front_cap <= 8'd220;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/wfc_decide.sv */
// Per-item decision logic: next controller state and the commands an item causes.
module wfc_decide (
  input  wfc_pkg::in_item_t          item_i,
  input  wfc_pkg::state_t            state_i,
  input  wfc_pkg::cfg_t              cfg_i,
  output wfc_pkg::state_t            state_o,
  output logic [wfc_pkg::CntW-1:0]   cnt_o,
  output wfc_pkg::result_t [1:0]     res_o
);

  always_comb begin
    logic [7:0]  l, c, r, s;
    logic [2:0]  arc_to, arc_away, spin_away, ph;
    logic [2:0]  front_cmd, front_phase;
    logic [9:0]  front_spd;
    logic [1:0]  n;
    logic        seek_left, front_near;
    wfc_pkg::state_t nxt;
    wfc_pkg::result_t [1:0] res;

    l = item_i.left_dist;
    c = item_i.center_dist;
    r = item_i.right_dist;
    s = state_i.wall_side ? r : l;
    arc_to = state_i.wall_side ? wfc_pkg::CmdArcR : wfc_pkg::CmdArcL;
    arc_away = state_i.wall_side ? wfc_pkg::CmdArcL : wfc_pkg::CmdArcR;
    spin_away = state_i.wall_side ? wfc_pkg::CmdSpinL : wfc_pkg::CmdSpinR;

    // Front stage outcome, shared by several follow cases
    front_near = (c <= cfg_i.near_limit);
    front_cmd = front_near ? spin_away : wfc_pkg::CmdFwd;
    front_spd = front_near ? cfg_i.turn_speed : cfg_i.follow_speed;
    front_phase = front_near ? wfc_pkg::PhFrontWait : wfc_pkg::PhFollow;

    // centre <= near_limit - 2, only when near_limit >= 2
    seek_left = (l <= cfg_i.near_limit) ||
                (({1'b0, c} + 9'd2) <= {1'b0, cfg_i.near_limit});

    nxt = state_i;
    n = 2'd0;
    res = '0;
    ph = state_i.phase;

    if (item_i.func == wfc_pkg::FuncActivate) begin
      nxt.active = 1'b1;
    end else if (item_i.func == wfc_pkg::FuncDeactivate) begin
      nxt.active = 1'b0;
      nxt.phase = state_i.wall_found ? wfc_pkg::PhFollow : wfc_pkg::PhSeek;
      res[0] = '{command: wfc_pkg::CmdStop, speed: 10'd0};
      n = 2'd1;
    end else if (item_i.func == wfc_pkg::FuncSample && state_i.active) begin
      if (!state_i.wall_found && ph >= wfc_pkg::PhFollow) begin
        ph = wfc_pkg::PhSeek;
      end
      nxt.phase = ph;
      unique case (ph)
        wfc_pkg::PhSeek: begin
          if (l < c && l < r) begin
            res[n[0]] = '{command: wfc_pkg::CmdSpinL, speed: cfg_i.turn_speed};
            n = n + 2'd1;
          end else if (r < c && r < l) begin
            res[n[0]] = '{command: wfc_pkg::CmdSpinR, speed: cfg_i.turn_speed};
            n = n + 2'd1;
          end
          if (seek_left) begin
            res[n[0]] = '{command: wfc_pkg::CmdSpinR, speed: cfg_i.turn_speed};
            nxt.phase = wfc_pkg::PhSeekAlL;
          end else if (r <= cfg_i.near_limit) begin
            res[n[0]] = '{command: wfc_pkg::CmdSpinL, speed: cfg_i.turn_speed};
            nxt.phase = wfc_pkg::PhSeekAlR;
          end else begin
            res[n[0]] = '{command: wfc_pkg::CmdFwd, speed: cfg_i.follow_speed};
          end
          n = n + 2'd1;
        end
        wfc_pkg::PhSeekAlL: begin
          if (c >= cfg_i.clear_limit) begin
            res[0] = '{command: wfc_pkg::CmdFwd, speed: cfg_i.follow_speed};
            n = 2'd1;
            nxt.wall_found = 1'b1;
            nxt.wall_side = 1'b0;
            nxt.phase = wfc_pkg::PhFollow;
          end
        end
        wfc_pkg::PhSeekAlR: begin
          if (c >= cfg_i.near_limit) begin
            res[0] = '{command: wfc_pkg::CmdFwd, speed: cfg_i.follow_speed};
            n = 2'd1;
            nxt.wall_found = 1'b1;
            nxt.wall_side = 1'b1;
            nxt.phase = wfc_pkg::PhFollow;
          end
        end
        wfc_pkg::PhFollow: begin
          if (s > cfg_i.far_limit) begin
            res[0] = '{command: arc_to, speed: cfg_i.follow_speed};
            res[1] = '{command: front_cmd, speed: front_spd};
            n = 2'd2;
            nxt.phase = front_phase;
          end else if (s >= cfg_i.near_limit) begin
            nxt.exit_dist = (c < cfg_i.front_cap) ? cfg_i.near_limit : cfg_i.front_cap;
            res[0] = '{command: arc_to,
                       speed: wfc_pkg::sat_add(cfg_i.turn_speed, wfc_pkg::ApproachBoost)};
            n = 2'd1;
            nxt.phase = wfc_pkg::PhMaxAppr;
          end else if (s <= cfg_i.min_limit) begin
            res[0] = '{command: arc_away,
                       speed: wfc_pkg::sat_add(cfg_i.turn_speed, wfc_pkg::RetreatBoost)};
            n = 2'd1;
            nxt.phase = wfc_pkg::PhMinWait;
          end else begin
            res[0] = '{command: front_cmd, speed: front_spd};
            n = 2'd1;
            nxt.phase = front_phase;
          end
        end
        wfc_pkg::PhMaxAppr: begin
          if (c <= cfg_i.near_limit && s > cfg_i.min_limit) begin
            res[0] = '{command: spin_away, speed: cfg_i.turn_speed};
            n = 2'd1;
            nxt.phase = wfc_pkg::PhMaxExit;
          end
        end
        wfc_pkg::PhMaxExit: begin
          if (c >= state_i.exit_dist) begin
            res[0] = '{command: wfc_pkg::CmdFwd, speed: cfg_i.follow_speed};
            res[1] = '{command: front_cmd, speed: front_spd};
            n = 2'd2;
            nxt.phase = front_phase;
          end
        end
        wfc_pkg::PhMinWait: begin
          if (c >= cfg_i.near_limit) begin
            res[0] = '{command: front_cmd, speed: front_spd};
            n = 2'd1;
            nxt.phase = front_phase;
          end
        end
        wfc_pkg::PhFrontWait: begin
          if (c >= cfg_i.near_limit) begin
            res[0] = '{command: wfc_pkg::CmdFwd, speed: cfg_i.follow_speed};
            n = 2'd1;
            nxt.phase = wfc_pkg::PhFollow;
          end
        end
        default: ;
      endcase
    end

    state_o = nxt;
    cnt_o = n;
    res_o = res;
  end

endmodule

/* hw/rtl/wfc_out_buf.sv */
// Result buffer: holds one item's commands and hands them out one per cycle while out_ready_i is high.
module wfc_out_buf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [wfc_pkg::CntW-1:0] cnt_i,
  input  wfc_pkg::result_t [1:0]   res_i,
  output logic                     load_ok_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output wfc_pkg::out_item_t       out_item_o
);

  logic [wfc_pkg::CntW-1:0] cnt_q, cnt_d;
  wfc_pkg::result_t [1:0]   slot_q, slot_d;
  logic                     pop;

  assign pop = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  // Room when empty, or when the only pending item leaves this cycle
  assign load_ok_o = (cnt_q == '0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d = cnt_q;
    slot_d = slot_q;
    if (load_i) begin
      cnt_d = cnt_i;
      slot_d = res_i;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_item_o.command = slot_q[0].command;
  assign out_item_o.speed = slot_q[0].speed;
  assign out_item_o.last = (cnt_q == 2'd1);

endmodule

/* hw/rtl/wall_follow_controller_unit.sv */
// Top level of the wall follow controller.
//
// Input channel (in_valid_i/in_ready_o/in_item_i) takes sensor samples and
// activate/deactivate commands. Output channel (out_valid_o/out_ready_i/
// out_item_o) returns motor commands, last set on the final command of an item.
// Config channel (cfg_valid_i/cfg_ready_o) writes register cfg_index_i with
// cfg_data_i; it is always ready and should be used while the block is idle.
// An item is registered on accept; from that register the decision logic
// updates the controller state and loads its commands into the result buffer
// once the buffer has room, which makes the first command valid at the output.
// An item causes zero to two commands, delivered one per cycle while
// out_ready_i is high; the single result port limits how fast items go through,
// and items with no command still pass through the input register.
// When the receiver stalls, the buffer holds its commands and the input
// register keeps one more item, after which in_ready_o drops.
// Reset restores default limits and speeds, seek phase, left wall, active.
module wall_follow_controller_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wfc_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wfc_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [9:0]          cfg_data_i
);

  wfc_pkg::cfg_t            cfg;
  wfc_pkg::state_t          state_q, state_d;
  wfc_pkg::in_item_t        s1_item_q;
  logic                     s1_valid_q;
  logic                     advance, load_ok;
  logic [wfc_pkg::CntW-1:0] dec_cnt;
  wfc_pkg::result_t [1:0]   dec_res;

  assign cfg_ready_o = 1'b1;

  wfc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance = s1_valid_q && load_ok;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  wfc_decide u_decide (
    .item_i (s1_item_q),
    .state_i(state_q),
    .cfg_i  (cfg),
    .state_o(state_d),
    .cnt_o  (dec_cnt),
    .res_o  (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= wfc_pkg::PhSeek;
      state_q.wall_found <= 1'b0;
      state_q.wall_side <= 1'b0;
      state_q.active <= 1'b1;
      state_q.exit_dist <= 8'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  wfc_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .cnt_i      (dec_cnt),
    .res_i      (dec_res),
    .load_ok_o  (load_ok),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // A deactivate item leaves the controller inactive
  a_deact_clears_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_item_q.func == wfc_pkg::FuncDeactivate) |=> !state_q.active)
    else $error("deactivate did not clear active");

  // Once found, the wall is never lost
  a_wall_found_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(state_q.wall_found))
    else $error("wall_found dropped");

  // Stop commands always carry zero speed
  a_stop_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.command == wfc_pkg::CmdStop) |-> out_item_o.speed == 10'd0)
    else $error("stop with nonzero speed");

  // Once a wall has been found, a sample item never moves the controller to a seek phase
  a_follow_needs_wall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_item_q.func == wfc_pkg::FuncSample && state_q.active &&
     state_d.wall_found) |-> (state_d.phase != wfc_pkg::PhSeek &&
     state_d.phase != wfc_pkg::PhSeekAlL && state_d.phase != wfc_pkg::PhSeekAlR))
    else $error("seek phase with wall found");

endmodule
